// ----- hdl/tbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg
// Shared types, widths and helpers of the Tanimoto bitset score core.
// ----------------------------------------------------------------------------
package tbs_pkg;

  localparam int WordW     = 64;
  localparam int SliceW    = 32;
  localparam int NumSlices = WordW / SliceW;
  localparam int SliceIdxW = (NumSlices > 1) ? $clog2(NumSlices) : 1;
  localparam int PopW      = $clog2(SliceW + 1);
  localparam int CountW    = 13;
  localparam int UnionW    = 14;
  localparam int FracBits  = 16;
  localparam int ScoreW    = FracBits + 1;
  localparam int RemW      = UnionW + 1;
  localparam int AluW      = RemW + 1;
  localparam int DivCntW   = $clog2(FracBits);

  localparam logic [CountW-1:0] CommonMax = {CountW{1'b1}};
  localparam logic [ScoreW-1:0] ScoreOne  = {1'b1, {FracBits{1'b0}}};

  typedef struct packed {
    logic [WordW-1:0]  exp_word;
    logic [WordW-1:0]  lib_word;
    logic              last_word;
    logic [CountW-1:0] exp_count;
    logic [CountW-1:0] lib_count;
  } tbs_in_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [CountW-1:0] common_bits;
    logic [UnionW-1:0] union_bits;
  } tbs_out_t;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_COUNT = 3'd1,
    OP_TOTAL = 3'd2,
    OP_UNION = 3'd3,
    OP_CMP   = 3'd4,
    OP_DIV   = 3'd5
  } alu_op_e;

  typedef struct packed {
    alu_op_e              op;
    logic                 step;
    logic                 load_in;
    logic                 emit;
    logic [SliceIdxW-1:0] slice;
  } tbs_ctrl_t;

  typedef struct packed {
    logic geq;
    logic last;
    logic no_score;
    logic out_busy;
  } tbs_status_t;

  function automatic logic [PopW-1:0] popcount32(input logic [SliceW-1:0] v);
    logic [2:0]      nib [SliceW/4];
    logic [PopW-1:0] acc;
    for (int i = 0; i < SliceW / 4; i++) begin
      nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    acc = '0;
    for (int i = 0; i < SliceW / 4; i++) begin
      acc = acc + PopW'(nib[i]);
    end
    return acc;
  endfunction

endpackage

// ----- hdl/tbs_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_alu
// Shared adder with carry in and carry out; subtracts when fed ~b and cin.
// ----------------------------------------------------------------------------
module tbs_alu (
  input  logic [tbs_pkg::AluW-1:0] a_i,
  input  logic [tbs_pkg::AluW-1:0] b_i,
  input  logic                     cin_i,
  output logic [tbs_pkg::AluW-1:0] sum_o,
  output logic                     cout_o
);
  import tbs_pkg::*;

  logic [AluW:0] full;

  assign full   = {1'b0, a_i} + {1'b0, b_i} + {{AluW{1'b0}}, cin_i};
  assign sum_o  = full[AluW-1:0];
  assign cout_o = full[AluW];

endmodule

// ----- hdl/tbs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_datapath
// Word registers, intersection accumulator, divider registers and the
// output register, all around one shared adder.
// ----------------------------------------------------------------------------
module tbs_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tbs_pkg::tbs_ctrl_t     ctrl_i,
  input  tbs_pkg::tbs_in_t       in_word_i,
  input  logic                   out_stall_i,
  output tbs_pkg::tbs_status_t   status_o,
  output logic                   out_valid_o,
  output tbs_pkg::tbs_out_t      out_word_o
);
  import tbs_pkg::*;

  logic [WordW-1:0]    and_q;
  logic                last_q;
  logic [CountW-1:0]   ec_q, lc_q;
  logic [CountW-1:0]   acc_q, acc_d;
  logic [RemW-1:0]     rem_q;
  logic [UnionW-1:0]   uni_q;
  logic [FracBits-1:0] quo_q;
  logic                sat_q;
  logic                out_valid_q, out_valid_d;
  tbs_out_t            out_q;

  logic [PopW-1:0]     pop;
  logic [AluW-1:0]     inter_ext, uni_ext, alu_a, alu_b, alu_sum;
  logic                alu_cin, alu_cout;
  logic [CountW-1:0]   count_sat;
  logic                zero_case;
  logic [ScoreW-1:0]   score;

  assign pop       = popcount32(and_q[ctrl_i.slice*SliceW +: SliceW]);
  assign inter_ext = AluW'(acc_q);
  assign uni_ext   = AluW'(uni_q);

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    case (ctrl_i.op)
      OP_COUNT: begin
        alu_a = inter_ext;
        alu_b = AluW'(pop);
      end
      OP_TOTAL: begin
        alu_a = AluW'(ec_q);
        alu_b = AluW'(lc_q);
      end
      OP_UNION: begin
        alu_a   = AluW'(rem_q);
        alu_b   = ~inter_ext;
        alu_cin = 1'b1;
      end
      OP_CMP: begin
        alu_a   = inter_ext;
        alu_b   = ~uni_ext;
        alu_cin = 1'b1;
      end
      OP_DIV: begin
        alu_a   = {rem_q, 1'b0};
        alu_b   = ~uni_ext;
        alu_cin = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  tbs_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .cin_i  (alu_cin),
    .sum_o  (alu_sum),
    .cout_o (alu_cout)
  );

  // clamp the running intersection at its largest code
  assign count_sat = (alu_sum > AluW'(CommonMax)) ? CommonMax : alu_sum[CountW-1:0];

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.emit) begin
      acc_d = '0;
    end else if (ctrl_i.step && ctrl_i.op == OP_COUNT) begin
      acc_d = count_sat;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      and_q  <= in_word_i.exp_word & in_word_i.lib_word;
      last_q <= in_word_i.last_word;
      ec_q   <= in_word_i.exp_count;
      lc_q   <= in_word_i.lib_count;
    end
    if (ctrl_i.step) begin
      case (ctrl_i.op)
        OP_TOTAL: rem_q <= alu_sum[RemW-1:0];
        // keep the difference only when total exceeds the intersection
        OP_UNION: uni_q <= alu_cout ? alu_sum[UnionW-1:0] : '0;
        OP_CMP: begin
          rem_q <= RemW'(acc_q);
          sat_q <= alu_cout;
        end
        OP_DIV: begin
          rem_q <= alu_cout ? alu_sum[RemW-1:0] : alu_a[RemW-1:0];
          quo_q <= {quo_q[FracBits-2:0], alu_cout};
        end
        default: begin
          sat_q <= sat_q;
        end
      endcase
    end
    if (ctrl_i.emit) begin
      out_q.score       <= score;
      out_q.common_bits <= acc_q;
      out_q.union_bits  <= uni_q;
    end
  end

  assign zero_case = ((ec_q == '0) && (lc_q == '0)) || (uni_q == '0);

  always_comb begin
    if (zero_case) begin
      score = '0;
    end else if (sat_q) begin
      score = ScoreOne;
    end else begin
      score = {1'b0, quo_q};
    end
  end

  assign status_o.geq      = alu_cout;
  assign status_o.last     = last_q;
  assign status_o.no_score = zero_case;
  assign status_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- hdl/tbs_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_seq
// Sequencer that steps the shared adder through counting, union and the
// bit-per-cycle division.
// ----------------------------------------------------------------------------
module tbs_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tbs_pkg::tbs_status_t  status_i,
  output tbs_pkg::tbs_ctrl_t    ctrl_o
);
  import tbs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_COUNT  = 7'b0000010,
    S_TOTAL  = 7'b0000100,
    S_UNION  = 7'b0001000,
    S_CMP    = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_FINISH = 7'b1000000
  } tbs_state_e;

  tbs_state_e           state_q, state_d;
  logic [SliceIdxW-1:0] slice_q, slice_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d        = state_q;
    slice_d        = slice_q;
    cnt_d          = cnt_q;
    ctrl_o.op      = OP_NONE;
    ctrl_o.step    = 1'b0;
    ctrl_o.load_in = 1'b0;
    ctrl_o.emit    = 1'b0;
    ctrl_o.slice   = slice_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          slice_d        = '0;
          state_d        = S_COUNT;
        end
      end
      S_COUNT: begin
        ctrl_o.op   = OP_COUNT;
        ctrl_o.step = 1'b1;
        if (slice_q == SliceIdxW'(NumSlices - 1)) begin
          slice_d = '0;
          state_d = status_i.last ? S_TOTAL : S_IDLE;
        end else begin
          slice_d = slice_q + 1'b1;
        end
      end
      S_TOTAL: begin
        ctrl_o.op   = OP_TOTAL;
        ctrl_o.step = 1'b1;
        state_d     = S_UNION;
      end
      S_UNION: begin
        ctrl_o.op   = OP_UNION;
        ctrl_o.step = 1'b1;
        state_d     = S_CMP;
      end
      S_CMP: begin
        if (status_i.no_score) begin
          state_d = S_FINISH;
        end else begin
          ctrl_o.op   = OP_CMP;
          ctrl_o.step = 1'b1;
          cnt_d       = '0;
          // intersection at or above union saturates, no division needed
          state_d     = status_i.geq ? S_FINISH : S_DIV;
        end
      end
      S_DIV: begin
        ctrl_o.op   = OP_DIV;
        ctrl_o.step = 1'b1;
        if (cnt_q == DivCntW'(FracBits - 1)) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          ctrl_o.emit = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slice_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      slice_q <= slice_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ----- hdl/tanimoto_bitset_score_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tanimoto_bitset_score_core
// Tanimoto similarity of two bit vectors streamed as 64-bit word pairs.
// ----------------------------------------------------------------------------
// A word pair is taken into the word registers and its AND is counted 32
// bits a cycle by the shared adder; a word that is not the last then frees
// the input. The last word then runs the count total, the union, the
// saturation compare and a restoring division of one quotient bit per cycle
// on the same adder (no compare without a score, no division at saturation),
// and S_FINISH loads the output register, held while an earlier result
// still waits under stall. The result sits in that register while the next
// vector's words are already taken.
module tanimoto_bitset_score_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbs_pkg::tbs_in_t   in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tbs_pkg::tbs_out_t  out_word_o
);
  import tbs_pkg::*;

  tbs_ctrl_t   ctrl;
  tbs_status_t status;

  tbs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  tbs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

// ----- hdl/tbs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_checker
// Port-level checks of the Tanimoto bitset score core, bound to the top.
// ----------------------------------------------------------------------------
module tbs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tbs_pkg::tbs_out_t  out_word_o
);
  import tbs_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed under stall");

  // the block is busy in the cycle after every accepted word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("word taken on back-to-back cycles");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.score <= ScoreOne)
    else $error("score above one");

  a_empty_union: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.union_bits == '0 |-> out_word_o.score == '0)
    else $error("nonzero score with empty union");

  // full score only when the intersection reaches the union
  a_full_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.score == ScoreOne
      |-> UnionW'(out_word_o.common_bits) >= out_word_o.union_bits)
    else $error("full score with intersection below union");

endmodule

bind tanimoto_bitset_score_core tbs_checker u_tbs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
